@@ rtl/quaternion_nlerp_unit_macros.svh @@
// Assertion macros shared by the checker of the quaternion nlerp unit.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef QUATERNION_NLERP_UNIT_MACROS_SVH
`define QUATERNION_NLERP_UNIT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define QNL_ASSERT_SAME(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("quaternion nlerp check failed");

// Condition must hold in the cycle after the trigger.
`define QNL_ASSERT_NEXT(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("quaternion nlerp check failed");

`endif

@@ rtl/qnl_pkg.sv @@
// Shared constants and stage types of the quaternion nlerp unit.
// Used by qnl_front and quaternion_nlerp_unit; depends on nothing.
package qnl_pkg;

	localparam int unsigned ONE_Q14 = 16384;
	localparam int unsigned N_STAGES = 20;
	localparam int unsigned N_TRIALS = 15;
	localparam int unsigned DW = 96;
	localparam int unsigned BW = 80;

	// Products formed in the first stage.
	typedef struct packed {
		logic [3:0][31:0] fg;
		logic [3:0][30:0] wf;
		logic [3:0][30:0] tg;
	} front_t;

	// Square root recurrence state of one component.
	typedef struct packed {
		logic signed [DW-1:0] d;
		logic signed [BW-1:0] b;
		logic [14:0]          k;
		logic                 neg;
	} lane_t;

	typedef struct packed {
		lane_t [3:0] lane;
		logic [61:0] len2;
	} root_t;

endpackage

@@ rtl/qnl_front.sv @@
// First stage arithmetic of the quaternion nlerp unit: blend clamp and products.
// Depends on qnl_pkg.
module qnl_front (
	input  logic signed [15:0] f [4],
	input  logic signed [15:0] g [4],
	input  logic [14:0]        blend,
	output qnl_pkg::front_t    prod
);

	logic [14:0] t;
	logic [14:0] w0;

	// Clamp the blend to one and form the weight of the first quaternion.
	always_comb begin
		t = (blend > 15'(qnl_pkg::ONE_Q14)) ? 15'(qnl_pkg::ONE_Q14) : blend;
		w0 = 15'(qnl_pkg::ONE_Q14) - t;
	end

	// Dot product terms and both weighted terms of every component.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			prod.fg[i] = 32'(f[i] * g[i]);
			prod.wf[i] = 31'($signed({1'b0, w0}) * f[i]);
			prod.tg[i] = 31'($signed({1'b0, t}) * g[i]);
		end
	end

endmodule

@@ rtl/quaternion_nlerp_unit.sv @@
// Top level of the quaternion nlerp unit: pipeline control, blend, length and root.
// Depends on qnl_pkg and qnl_front.
//
// Usage: each request on the s_axis channel carries two quaternions and a blend
// factor; the m_axis channel returns one normalized quaternion per request, in
// order, with m_axis_tuser set when the blended length is zero (outputs zero).
// The pipeline has 20 register stages: one of products, one of blending, one of
// squaring, one of length summing, fifteen of the shift-and-subtract root
// recurrence (one result bit each) and the output register. The stage one
// register loads at the accepting edge, and the request then passes through
// every later stage in order until the output register raises m_axis_tvalid.
// Throughput is one request per cycle while the receiver does not stall, set by
// the fully pipelined recurrence; every stage holds its own request.
// Reset clears all valid bits; the pipeline starts empty and ready.
// When the receiver stalls, the output register holds its result and earlier
// stages keep filling their empty slots, so s_axis_tready drops only once every
// stage holds a request. Nothing is lost or repeated across a stall.
module quaternion_nlerp_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// from_x, from_y, from_z, from_w, to_x, to_y, to_z, to_w (16 each), blend (15), pad
	input  logic [143:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_x, out_y, out_z, out_w (16 each)
	output logic [63:0]  m_axis_tdata,
	// degenerate
	output logic         m_axis_tuser
);

	logic [qnl_pkg::N_STAGES:1] vld_s;
	logic [qnl_pkg::N_STAGES:1] en;

	logic signed [15:0] f_in [4];
	logic signed [15:0] g_in [4];
	qnl_pkg::front_t    prod;

	qnl_pkg::front_t    prod_s1;
	logic [30:0]        r_s2 [4];
	logic [59:0]        sq_s3 [4];
	logic [3:0]         neg_s3;
	qnl_pkg::root_t     rt_s [qnl_pkg::N_TRIALS+1];
	logic [63:0]        dat_s20;
	logic               deg_s20;

	// A stage loads when it is empty or its successor loads.
	always_comb begin
		en[qnl_pkg::N_STAGES] = !vld_s[qnl_pkg::N_STAGES] || m_axis_tready;
		for (int i = qnl_pkg::N_STAGES - 1; i >= 1; i--) begin
			en[i] = !vld_s[i] || en[i+1];
		end
	end

	assign s_axis_tready = en[1];
	assign m_axis_tvalid = vld_s[qnl_pkg::N_STAGES];
	assign m_axis_tdata  = dat_s20;
	assign m_axis_tuser  = deg_s20;

	// Valid bits travel with the requests.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1]) begin
				vld_s[1] <= s_axis_tvalid;
			end
			for (int i = 2; i <= qnl_pkg::N_STAGES; i++) begin
				if (en[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	// Unpack the request.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			f_in[i] = s_axis_tdata[16*i +: 16];
			g_in[i] = s_axis_tdata[64 + 16*i +: 16];
		end
	end

	qnl_front u_front (
		.f     (f_in),
		.g     (g_in),
		.blend (s_axis_tdata[142:128]),
		.prod  (prod)
	);

	// Stage one: products.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			prod_s1 <= prod;
		end
	end

	// Stage two: dot product sign picks the short arc, then blend.
	logic signed [33:0] dot;
	always_comb begin
		dot = '0;
		for (int i = 0; i < 4; i++) begin
			dot = dot + 34'($signed(prod_s1.fg[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 4; i++) begin
				if (dot > 34'sd0) begin
					r_s2[i] <= prod_s1.wf[i] + prod_s1.tg[i];
				end else begin
					r_s2[i] <= prod_s1.wf[i] - prod_s1.tg[i];
				end
			end
		end
	end

	// Stage three: magnitude squared of each component.
	logic [29:0] mag [4];
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mag[i] = r_s2[i][30] ? 30'(-r_s2[i]) : r_s2[i][29:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int i = 0; i < 4; i++) begin
				sq_s3[i]  <= mag[i] * mag[i];
				neg_s3[i] <= r_s2[i][30];
			end
		end
	end

	// Stage four: squared length and the initial remainders for k = 0.
	logic [61:0] len2;
	always_comb begin
		len2 = 62'(sq_s3[0]) + 62'(sq_s3[1]) + 62'(sq_s3[2]) + 62'(sq_s3[3]);
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			rt_s[0].len2 <= len2;
			for (int i = 0; i < 4; i++) begin
				rt_s[0].lane[i].d   <= $signed({6'b0, sq_s3[i], 30'b0}) -
					$signed({34'b0, len2});
				rt_s[0].lane[i].b   <= -$signed({18'b0, len2});
				rt_s[0].lane[i].k   <= '0;
				rt_s[0].lane[i].neg <= neg_s3[i];
			end
		end
	end

	// Root stages: each decides one bit of k, most significant first. With
	// a = 2k-1 the remainder is d = 2^30*mag^2 - a^2*L and b = a*L, so trying
	// a bit needs only shifted adds of b and L.
	for (genvar n = 1; n <= qnl_pkg::N_TRIALS; n++) begin : g_trial
		localparam int J = qnl_pkg::N_TRIALS - n;
		logic signed [qnl_pkg::DW-1:0] trial [4];

		always_comb begin
			for (int i = 0; i < 4; i++) begin
				trial[i] = rt_s[n-1].lane[i].d
					- ($signed(qnl_pkg::DW'(rt_s[n-1].lane[i].b)) <<< (J + 2))
					- $signed(qnl_pkg::DW'(rt_s[n-1].len2) << (2*J + 2));
			end
		end

		always_ff @(posedge clk) begin
			if (en[4+n]) begin
				rt_s[n].len2 <= rt_s[n-1].len2;
				for (int i = 0; i < 4; i++) begin
					rt_s[n].lane[i].neg <= rt_s[n-1].lane[i].neg;
					if (!trial[i][qnl_pkg::DW-1]) begin
						rt_s[n].lane[i].d <= trial[i];
						rt_s[n].lane[i].b <= rt_s[n-1].lane[i].b +
							$signed(qnl_pkg::BW'(rt_s[n-1].len2) << (J + 1));
						rt_s[n].lane[i].k <= rt_s[n-1].lane[i].k | (15'd1 << J);
					end else begin
						rt_s[n].lane[i].d <= rt_s[n-1].lane[i].d;
						rt_s[n].lane[i].b <= rt_s[n-1].lane[i].b;
						rt_s[n].lane[i].k <= rt_s[n-1].lane[i].k;
					end
				end
			end
		end
	end

	// Output stage: saturate, restore the sign, zero a degenerate blend.
	logic [14:0] kc [4];
	logic        deg;
	always_comb begin
		deg = (rt_s[qnl_pkg::N_TRIALS].len2 == '0);
		for (int i = 0; i < 4; i++) begin
			kc[i] = rt_s[qnl_pkg::N_TRIALS].lane[i].k;
			if (kc[i] > 15'(qnl_pkg::ONE_Q14)) begin
				kc[i] = 15'(qnl_pkg::ONE_Q14);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[qnl_pkg::N_STAGES]) begin
			deg_s20 <= deg;
			for (int i = 0; i < 4; i++) begin
				if (deg) begin
					dat_s20[16*i +: 16] <= '0;
				end else if (rt_s[qnl_pkg::N_TRIALS].lane[i].neg) begin
					dat_s20[16*i +: 16] <= 16'd0 - {1'b0, kc[i]};
				end else begin
					dat_s20[16*i +: 16] <= {1'b0, kc[i]};
				end
			end
		end
	end

endmodule

@@ rtl/qnl_checker.sv @@
// Port-level checks of the quaternion nlerp unit, bound to the top level.
// Depends on quaternion_nlerp_unit_macros.svh.
`include "quaternion_nlerp_unit_macros.svh"

module qnl_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [143:0] s_axis_tdata,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [63:0]  m_axis_tdata,
	input logic         m_axis_tuser
);

	// A stalled result holds.
	`QNL_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// A degenerate blend returns a zero quaternion.
	`QNL_ASSERT_SAME(a_deg_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 64'd0)

	// Every component stays within plus or minus one.
	`QNL_ASSERT_SAME(a_range, m_axis_tvalid, ($signed(m_axis_tdata[15:0]) <= 16'sd16384) && ($signed(m_axis_tdata[15:0]) >= -16'sd16384) && ($signed(m_axis_tdata[31:16]) <= 16'sd16384) && ($signed(m_axis_tdata[31:16]) >= -16'sd16384) && ($signed(m_axis_tdata[47:32]) <= 16'sd16384) && ($signed(m_axis_tdata[47:32]) >= -16'sd16384) && ($signed(m_axis_tdata[63:48]) <= 16'sd16384) && ($signed(m_axis_tdata[63:48]) >= -16'sd16384))

	// With the output register empty the whole pipeline can move.
	`QNL_ASSERT_SAME(a_ready, !m_axis_tvalid, s_axis_tready)

endmodule

bind quaternion_nlerp_unit qnl_checker u_qnl_checker (.*);
